FILE: src/gfj_pkg.sv
// Shared constants and types of the greedy full text justifier.
package gfj_pkg;

  localparam int MAX_WIDTH = 32;
  localparam int MAX_WORDS = 16;
  localparam int WW        = 6;   // width of a character count, 0..32
  localparam int IW        = 5;   // index into a 32-entry line or word buffer
  localparam int CW        = 5;   // word count of a line, 0..16
  localparam logic [7:0]    SPACE_CHAR = 8'd32;
  localparam logic [WW-1:0] MAX_W      = WW'(MAX_WIDTH);
  localparam logic [WW-1:0] RESET_W    = 6'd16;

  // One finished word handed from the front to the back.
  typedef struct packed {
    logic          bank;  // word buffer bank that holds the characters
    logic [WW-1:0] len;   // word length after the cut to the line width
    logic          cut;   // the word was cut
    logic          tend;  // the word is the last one of the text
  } cmd_t;

  // One result character.
  typedef struct packed {
    logic [7:0] ch;
    logic       line_last;
    logic       run_last;
    logic       trunc;
  } out_t;

endpackage

FILE: src/gfj_front.sv
// Front part: collects word characters into two banks and queues finished words.
module gfj_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [gfj_pkg::WW-1:0] eff_w,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_in,
  input  logic               word_end,
  input  logic               text_end,
  output logic               cmd_valid,
  output gfj_pkg::cmd_t      cmd,
  input  logic               cmd_pop,
  input  logic [gfj_pkg::IW:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] wmem [0:2*gfj_pkg::MAX_WIDTH-1];
  gfj_pkg::cmd_t q [0:1];
  logic [1:0] count;
  logic wbank;
  logic rbank;
  logic [gfj_pkg::WW-1:0] cwl;
  logic cut;
  logic accept;
  logic keep;
  logic [gfj_pkg::WW-1:0] cwl_new;
  logic cut_new;
  gfj_pkg::cmd_t cmd_new;

  assign full = (count == 2'd2);
  assign accept = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd = q[rbank];

  // Classify the character: keep it, or mark the word as cut.
  always_comb begin
    keep    = (cwl < gfj_pkg::MAX_W);
    cwl_new = keep ? cwl + 6'd1 : cwl;
    cut_new = cut || !keep;
    cmd_new.bank = wbank;
    cmd_new.len  = (cwl_new > eff_w) ? eff_w : cwl_new;
    cmd_new.cut  = cut_new || (cwl_new > eff_w);
    cmd_new.tend = text_end;
  end

  // Word buffer memory with a registered read port for the back part.
  always_ff @(posedge clk) begin
    if (accept && keep) begin
      wmem[{wbank, cwl[gfj_pkg::IW-1:0]}] <= char_in;
    end
    rd_data <= wmem[rd_addr];
  end

  // Word queue entries, one per bank.
  always_ff @(posedge clk) begin
    if (accept && word_end) begin
      q[wbank] <= cmd_new;
    end
  end

  // Word counters and queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wbank <= 1'b0;
      rbank <= 1'b0;
      cwl   <= '0;
      cut   <= 1'b0;
    end else begin
      if (accept) begin
        if (word_end) begin
          cwl   <= '0;
          cut   <= 1'b0;
          wbank <= !wbank;
        end else begin
          cwl <= cwl_new;
          cut <= cut_new;
        end
      end
      if (cmd_pop) begin
        rbank <= !rbank;
      end
      count <= count + {1'b0, accept && word_end} - {1'b0, cmd_pop};
    end
  end

endmodule

FILE: src/gfj_back.sv
// Back part: fills the line buffer and emits lines, justified but for the last.
module gfj_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [gfj_pkg::WW-1:0] eff_w,
  input  logic               cmd_valid,
  input  gfj_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic [gfj_pkg::IW:0] rd_addr,
  input  logic [7:0]         rd_data,
  output logic               oq_push,
  output gfj_pkg::out_t      oq_item,
  input  logic               oq_full
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_EMIT, S_COPY, S_COPY_END} state_t;
  typedef enum logic [1:0] {P_WORD, P_GAP, P_PAD} phase_t;

  state_t state;
  phase_t phase;
  gfj_pkg::cmd_t cur;
  logic [gfj_pkg::WW-1:0] letters;
  logic [gfj_pkg::CW-1:0] wc;
  logic ov;
  logic [gfj_pkg::WW-1:0] wlen [0:gfj_pkg::MAX_WORDS-1];
  logic [7:0] line_mem [0:gfj_pkg::MAX_WIDTH-1];
  logic final_line;
  logic [gfj_pkg::WW-1:0] base;
  logic [3:0] remq;
  logic [2:0] dcnt;
  logic [gfj_pkg::WW-1:0] dq;
  logic [3:0] drem;
  logic [3:0] dvs;
  logic [3:0] k;
  logic [gfj_pkg::WW-1:0] ilen;
  logic [gfj_pkg::WW-1:0] src;
  logic [gfj_pkg::WW-1:0] pos;
  logic [gfj_pkg::WW-1:0] gcnt;
  logic [gfj_pkg::WW-1:0] ci;
  logic cp_valid;
  logic [gfj_pkg::IW-1:0] cp_dst;

  logic [6:0] need;
  logic flush;
  logic [gfj_pkg::WW-1:0] extra;
  logic [4:0] r2;
  logic ge;
  logic [3:0] drem_n;
  logic [gfj_pkg::WW-1:0] dq_n;
  logic emit_fire;
  logic emit_last;
  logic [gfj_pkg::WW-1:0] gap;
  logic more_words;

  // Fit test of the incoming word and the extra space count of a flushed line.
  always_comb begin
    need  = 7'(letters) + 7'(wc) + 7'(cmd.len);
    flush = (wc != '0) && ((need > 7'(eff_w)) || (wc >= 5'(gfj_pkg::MAX_WORDS)));
    extra = (eff_w > letters) ? eff_w - letters : '0;
  end

  // One restoring division step per cycle.
  always_comb begin
    r2     = {drem, dq[gfj_pkg::WW-1]};
    ge     = (r2 >= {1'b0, dvs});
    drem_n = ge ? 4'(r2 - {1'b0, dvs}) : r2[3:0];
    dq_n   = {dq[gfj_pkg::WW-2:0], ge};
  end

  // Character emission.
  always_comb begin
    emit_fire  = (state == S_EMIT) && !oq_full;
    emit_last  = (pos == eff_w - 6'd1);
    more_words = ({1'b0, k} + 5'd1) < wc;
    gap        = base + {5'd0, ({1'b0, k} < {1'b0, remq})};
    oq_push    = emit_fire;
    oq_item.ch        = (phase == P_WORD) ? line_mem[src[gfj_pkg::IW-1:0]] : gfj_pkg::SPACE_CHAR;
    oq_item.line_last = emit_last;
    oq_item.run_last  = emit_last && (final_line || !cur.tend);
    oq_item.trunc     = ov;
    cmd_pop = (emit_fire && emit_last && final_line) ||
              ((state == S_COPY_END) && !cur.tend);
    rd_addr = {cur.bank, ci[gfj_pkg::IW-1:0]};
  end

  // Line buffer writes from the word copy.
  always_ff @(posedge clk) begin
    if (cp_valid) begin
      line_mem[cp_dst] <= rd_data;
    end
    if ((state == S_COPY_END) && (wc < 5'(gfj_pkg::MAX_WORDS))) begin
      wlen[wc[3:0]] <= cur.len;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= P_WORD;
      letters    <= '0;
      wc         <= '0;
      ov         <= 1'b0;
      cp_valid   <= 1'b0;
      final_line <= 1'b0;
    end else begin
      cp_valid <= (state == S_COPY);
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            ci  <= '0;
            if (flush) begin
              final_line <= 1'b0;
              dq   <= extra;
              drem <= '0;
              dvs  <= 4'(wc - 5'd1);
              dcnt <= '0;
              state <= S_DIV;
            end else begin
              state <= S_COPY;
            end
          end
        end
        S_DIV: begin
          dq   <= dq_n;
          drem <= drem_n;
          dcnt <= dcnt + 3'd1;
          if (dcnt == 3'(gfj_pkg::WW - 1)) begin
            base  <= dq_n;
            remq  <= drem_n;
            k     <= '0;
            ilen  <= wlen[0];
            src   <= '0;
            pos   <= '0;
            phase <= P_WORD;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            pos <= pos + 6'd1;
            case (phase)
              P_WORD: begin
                src <= src + 6'd1;
                if (ilen == 6'd1) begin
                  if (more_words) begin
                    if (gap == '0) begin
                      k    <= k + 4'd1;
                      ilen <= wlen[k + 4'd1];
                    end else begin
                      gcnt  <= gap;
                      phase <= P_GAP;
                    end
                  end else begin
                    phase <= P_PAD;
                  end
                end else begin
                  ilen <= ilen - 6'd1;
                end
              end
              P_GAP: begin
                if (gcnt == 6'd1) begin
                  k     <= k + 4'd1;
                  ilen  <= wlen[k + 4'd1];
                  phase <= P_WORD;
                end else begin
                  gcnt <= gcnt - 6'd1;
                end
              end
              default: begin
              end
            endcase
            if (emit_last) begin
              letters <= '0;
              wc      <= '0;
              ov      <= 1'b0;
              ci      <= '0;
              state   <= final_line ? S_IDLE : S_COPY;
            end
          end
        end
        S_COPY: begin
          cp_dst <= letters[gfj_pkg::IW-1:0] + ci[gfj_pkg::IW-1:0];
          ci     <= ci + 6'd1;
          if (ci == cur.len - 6'd1) begin
            state <= S_COPY_END;
          end
        end
        S_COPY_END: begin
          letters <= letters + cur.len;
          wc      <= wc + 5'd1;
          ov      <= ov || cur.cut;
          if (cur.tend) begin
            final_line <= 1'b1;
            base  <= 6'd1;
            remq  <= '0;
            k     <= '0;
            ilen  <= (wc == '0) ? cur.len : wlen[0];
            src   <= '0;
            pos   <= '0;
            phase <= P_WORD;
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/gfj_outq.sv
// Result queue between the back part and the result ports.
module gfj_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  gfj_pkg::out_t wr_item,
  output logic          full,
  input  logic          rd,
  output gfj_pkg::out_t rd_item,
  output logic          empty
);

  gfj_pkg::out_t mem [0:3];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;
  logic do_wr;
  logic do_rd;

  assign full    = (count == 3'd4);
  assign empty   = (count == 3'd0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_item = mem[rptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 2'd1;
      end
      if (do_rd) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + {2'd0, do_wr} - {2'd0, do_rd};
    end
  end

endmodule

FILE: src/greedy_full_text_justifier.sv
// Greedy full text justifier: one character per transfer in, justified lines out.
// Input takes one character per cycle while full is low; full rises only while two finished words wait.
// The back part copies each word into the line buffer; a flushed line first divides its spare spaces.
// A line then leaves at one character per cycle while the result queue has room, eff_w characters long.
// Reset (synchronous, rst high) clears all control state and sets the width register to 16.
module greedy_full_text_justifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in,
  input  logic       word_end,
  input  logic       text_end,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] char_out,
  output logic       line_last,
  output logic       run_last,
  output logic       truncated,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] line_width
);

  logic [gfj_pkg::WW-1:0] width_reg;
  logic [gfj_pkg::WW-1:0] eff_w;
  logic cmd_valid;
  gfj_pkg::cmd_t cmd;
  logic cmd_pop;
  logic [gfj_pkg::IW:0] rd_addr;
  logic [7:0] rd_data;
  logic oq_push;
  gfj_pkg::out_t oq_item;
  logic oq_full;
  gfj_pkg::out_t rd_item;

  assign cfg_ready = 1'b1;

  // Line width register.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= gfj_pkg::RESET_W;
    end else if (cfg_valid && cfg_ready) begin
      width_reg <= line_width;
    end
  end

  // Width in effect, held to 1..32.
  always_comb begin
    if (width_reg == '0) begin
      eff_w = 6'd1;
    end else if (width_reg > gfj_pkg::MAX_W) begin
      eff_w = gfj_pkg::MAX_W;
    end else begin
      eff_w = width_reg;
    end
  end

  gfj_front u_front (
    .clk(clk), .rst(rst), .eff_w(eff_w),
    .push(push), .full(full), .char_in(char_in),
    .word_end(word_end), .text_end(text_end),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  gfj_back u_back (
    .clk(clk), .rst(rst), .eff_w(eff_w),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .rd_addr(rd_addr), .rd_data(rd_data),
    .oq_push(oq_push), .oq_item(oq_item), .oq_full(oq_full)
  );

  gfj_outq u_outq (
    .clk(clk), .rst(rst),
    .wr(oq_push), .wr_item(oq_item), .full(oq_full),
    .rd(pop), .rd_item(rd_item), .empty(empty)
  );

  assign char_out  = rd_item.ch;
  assign line_last = rd_item.line_last;
  assign run_last  = rd_item.run_last;
  assign truncated = rd_item.trunc;

`ifndef NO_ASSERTIONS
  // The back part never writes into a full result queue.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst) !(oq_push && oq_full))
    else $error("result queue overrun");

  // A word is only taken from the front when one is waiting.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) cmd_pop |-> cmd_valid)
    else $error("word queue underrun");

  // The last result of an item always closes a line.
  a_run_on_line: assert property (@(posedge clk) disable iff (rst)
    (!empty && run_last) |-> line_last)
    else $error("run end inside a line");
`endif

endmodule
